// ===== sv/bxd_pkg.sv =====
// ----------------------------------------------------------------------------
// bxd_pkg
// Shared types and constants of the box average downscaler: pixel and
// register widths, register indexes and the position flags handed from the
// position tracker to the datapath.
// ----------------------------------------------------------------------------
package bxd_pkg;

    localparam int PIX_W      = 16;
    localparam int LW_W       = 13;
    localparam int FH_W       = 16;
    localparam int BS_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CH_N       = 3;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 13'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
    localparam logic [BS_W-1:0] BLOCK_SCALE_RST  = 5'd1;

    typedef logic [PIX_W-1:0] pix_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BLOCK_SCALE  = 2'd2
    } cfg_index_t;

    // where the current item sits in the frame
    typedef struct packed {
        logic in_full;    // pixel belongs to a whole block
        logic first;      // top-left pixel of its block
        logic emit;       // bottom-right pixel of its block
        logic frame_end;  // block is the last whole block of the frame
    } bxd_pos_t;

endpackage

// ===== sv/bxd_ram.sv =====
// ----------------------------------------------------------------------------
// bxd_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data. A read and a write to the same address in one cycle return the old
// contents.
// ----------------------------------------------------------------------------
module bxd_ram #(
    parameter int DATA_W = 72,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bxd_position.sv =====
// ----------------------------------------------------------------------------
// bxd_position
// Configuration registers and raster position tracking. Clamps the
// registers to their usable ranges, keeps pixel, block and in-block
// counters, and flags each item as first, last or outside a whole block.
// ----------------------------------------------------------------------------
module bxd_position
    import bxd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_wr_data,
    input  logic                              advance,
    output bxd_pos_t                          pos,
    output logic [$clog2(MAX_WIDTH)-1:0]      blk_addr,
    output logic [2*$clog2(MAX_SCALE+1)-1:0]  area
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = $clog2(MAX_WIDTH + 2 * MAX_SCALE + 1);
    localparam int SC_W = $clog2(MAX_SCALE + 1);
    localparam int RXW = FH_W + 1;

    logic [LW_W-1:0] line_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [BS_W-1:0] block_scale_reg;

    logic [WW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic [SC_W-1:0] eff_s;
    logic            cfg_hit;

    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   col_start_reg, col_start_next;
    logic [CW-1:0]   blk_reg, blk_next;
    logic [SC_W-1:0] cib_reg, cib_next;
    logic [SC_W-1:0] rib_reg, rib_next;
    logic [FH_W-1:0] row_reg, row_next;
    logic [FH_W-1:0] row_start_reg, row_start_next;

    logic [XW-1:0]   col_reach1, col_reach2;
    logic [RXW-1:0]  row_reach1, row_reach2;
    logic            col_last, row_last, cib_wrap, rib_wrap;

    // decode writes to known registers
    always_comb begin
        unique case (cfg_index_t'(cfg_index))
            CFG_LINE_WIDTH, CFG_FRAME_HEIGHT, CFG_BLOCK_SCALE: cfg_hit = cfg_wr_en;
            default:                                          cfg_hit = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            block_scale_reg  <= BLOCK_SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_wr_data[LW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[FH_W-1:0];
                CFG_BLOCK_SCALE:  block_scale_reg  <= cfg_wr_data[BS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp registers to usable values
    always_comb begin
        if (line_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(line_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(line_width_reg);
        end
        eff_h = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
        if (block_scale_reg == '0) begin
            eff_s = SC_W'(1);
        end else if (32'(block_scale_reg) > MAX_SCALE) begin
            eff_s = SC_W'(MAX_SCALE);
        end else begin
            eff_s = SC_W'(block_scale_reg);
        end
    end

    assign area = (2*SC_W)'(eff_s) * (2*SC_W)'(eff_s);

    // reach of the current and the following block column and row
    assign col_reach1 = XW'(col_start_reg) + XW'(eff_s);
    assign col_reach2 = col_reach1 + XW'(eff_s);
    assign row_reach1 = RXW'(row_start_reg) + RXW'(eff_s);
    assign row_reach2 = row_reach1 + RXW'(eff_s);

    assign col_last = (XW'(col_reg) + XW'(1)) >= XW'(eff_w);
    assign row_last = (RXW'(row_reg) + RXW'(1)) >= RXW'(eff_h);
    assign cib_wrap = (cib_reg + SC_W'(1)) >= eff_s;
    assign rib_wrap = (rib_reg + SC_W'(1)) >= eff_s;

    // flags for the current item
    always_comb begin
        pos.in_full   = (col_reach1 <= XW'(eff_w)) && (row_reach1 <= RXW'(eff_h));
        pos.first     = (cib_reg == '0) && (rib_reg == '0);
        pos.emit      = cib_wrap && rib_wrap;
        pos.frame_end = (col_reach2 > XW'(eff_w)) && (row_reach2 > RXW'(eff_h));
    end

    assign blk_addr = blk_reg;

    // advance the raster position
    always_comb begin
        col_next       = col_reg;
        col_start_next = col_start_reg;
        blk_next       = blk_reg;
        cib_next       = cib_reg;
        rib_next       = rib_reg;
        row_next       = row_reg;
        row_start_next = row_start_reg;
        if (cfg_hit) begin
            col_next       = '0;
            col_start_next = '0;
            blk_next       = '0;
            cib_next       = '0;
            rib_next       = '0;
            row_next       = '0;
            row_start_next = '0;
        end else if (advance) begin
            if (col_last) begin
                col_next       = '0;
                col_start_next = '0;
                blk_next       = '0;
                cib_next       = '0;
                if (row_last) begin
                    row_next       = '0;
                    row_start_next = '0;
                    rib_next       = '0;
                end else begin
                    row_next = row_reg + FH_W'(1);
                    if (rib_wrap) begin
                        rib_next       = '0;
                        row_start_next = row_reg + FH_W'(1);
                    end else begin
                        rib_next = rib_reg + SC_W'(1);
                    end
                end
            end else begin
                col_next = col_reg + CW'(1);
                if (cib_wrap) begin
                    cib_next       = '0;
                    blk_next       = blk_reg + CW'(1);
                    col_start_next = col_reg + CW'(1);
                end else begin
                    cib_next = cib_reg + SC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            col_start_reg <= '0;
            blk_reg       <= '0;
            cib_reg       <= '0;
            rib_reg       <= '0;
            row_reg       <= '0;
            row_start_reg <= '0;
        end else begin
            col_reg       <= col_next;
            col_start_reg <= col_start_next;
            blk_reg       <= blk_next;
            cib_reg       <= cib_next;
            rib_reg       <= rib_next;
            row_reg       <= row_next;
            row_start_reg <= row_start_next;
        end
    end

endmodule

// ===== sv/bxd_divider.sv =====
// ----------------------------------------------------------------------------
// bxd_divider
// Three-channel restoring divider: divides each block sum by the block
// area, one quotient bit per cycle, and holds the quotients until taken.
// ----------------------------------------------------------------------------
module bxd_divider
    import bxd_pkg::*;
#(
    parameter int SUM_W  = 24,
    parameter int AREA_W = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [CH_N-1:0][SUM_W-1:0] sums,
    input  logic [AREA_W-1:0]          area,
    input  logic                       frame_end_in,
    output logic                       busy,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [CH_N-1:0][PIX_W-1:0] quot,
    output logic                       frame_end_out
);

    localparam int QCW = $clog2(PIX_W);

    logic [CH_N-1:0][SUM_W-1:0] rem_reg, rem_next;
    logic [CH_N-1:0][PIX_W-1:0] quot_reg, quot_next;
    logic [SUM_W-1:0]           dsh_reg;
    logic [QCW-1:0]             cnt_reg;
    logic                       running_reg;
    logic                       pend_reg;
    logic                       fe_reg;

    // one compare and subtract per channel
    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            if (rem_reg[c] >= dsh_reg) begin
                rem_next[c]  = rem_reg[c] - dsh_reg;
                quot_next[c] = {quot_reg[c][PIX_W-2:0], 1'b1};
            end else begin
                rem_next[c]  = rem_reg[c];
                quot_next[c] = {quot_reg[c][PIX_W-2:0], 1'b0};
            end
        end
    end

    // datapath: load on start, step while running
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= sums;
            dsh_reg <= SUM_W'(area) << (PIX_W - 1);
            fe_reg  <= frame_end_in;
        end else if (running_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    // control: step count and result hold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (start) begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end else if (running_reg) begin
                cnt_reg <= cnt_reg + QCW'(1);
                if (cnt_reg == QCW'(PIX_W - 1)) begin
                    running_reg <= 1'b0;
                    pend_reg    <= 1'b1;
                end
            end else if (pend_reg && out_ready) begin
                pend_reg <= 1'b0;
            end
        end
    end

    assign busy          = running_reg || pend_reg;
    assign out_valid     = pend_reg;
    assign quot          = quot_reg;
    assign frame_end_out = fe_reg;

endmodule

// ===== sv/box_average_downscaler.sv =====
// ----------------------------------------------------------------------------
// box_average_downscaler
// Averages each whole block of block_scale x block_scale pixels of a raster
// RGB stream into one output pixel.
// ----------------------------------------------------------------------------
// A pixel that does not complete a block is taken in one per cycle while the
// divider is free: its position is looked up, the block column's partial sums
// are read from one shared RAM (registered read data) and written back in the
// following cycle, with the just-written sums forwarded when the next pixel
// hits the same column. A pixel that completes a block (the bottom-right one)
// holds the input while its sum is finished, while the shared bit-per-cycle
// divider divides all three sums by block_scale squared, and until hand-off.
// The result then waits in the output register while input pixels keep
// flowing. Writing any register restarts the frame position.
// The sum RAM is not cleared: each block's entry is written at its first
// pixel before it is read.
// ----------------------------------------------------------------------------
module box_average_downscaler
    import bxd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_red_in,
    input  logic [PIX_W-1:0]      s_green_in,
    input  logic [PIX_W-1:0]      s_blue_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_red_avg,
    output logic [PIX_W-1:0]      m_green_avg,
    output logic [PIX_W-1:0]      m_blue_avg,
    output logic                  m_frame_end
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int SC_W   = $clog2(MAX_SCALE + 1);
    localparam int AREA_W = 2 * SC_W;
    localparam int SUM_W  = PIX_W + 2 * $clog2(MAX_SCALE);
    localparam int MEM_W  = CH_N * SUM_W;

    bxd_pos_t          pos;
    logic [AW-1:0]     blk_addr;
    logic [AREA_W-1:0] area;
    logic              accept;

    // write-back stage
    logic                       s1_valid_reg;
    logic                       s1_first_reg;
    logic                       s1_emit_reg;
    logic                       s1_fe_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic [CH_N-1:0][PIX_W-1:0] s1_pix_reg;
    logic                       fwd_reg;
    logic [MEM_W-1:0]           fwd_data_reg;

    logic [MEM_W-1:0]           rd_data;
    logic [MEM_W-1:0]           base;
    logic [CH_N-1:0][SUM_W-1:0] sum_next;

    // divider and output register
    logic                       div_busy;
    logic                       div_valid;
    logic                       div_take;
    logic [CH_N-1:0][PIX_W-1:0] div_quot;
    logic                       div_fe;
    logic                       m_valid_reg;
    logic [CH_N-1:0][PIX_W-1:0] m_avg_reg;
    logic                       m_fe_reg;

    bxd_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .advance     (accept),
        .pos         (pos),
        .blk_addr    (blk_addr),
        .area        (area)
    );

    // accept while the divider is free and no block result is in flight
    assign s_ready = !div_busy && !(s1_valid_reg && s1_emit_reg);
    assign accept  = s_valid && s_ready;

    bxd_ram #(
        .DATA_W (MEM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (sum_next),
        .rd_en   (accept),
        .rd_addr (blk_addr),
        .rd_data (rd_data)
    );

    // capture the item and forward the sums written in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept && pos.in_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_first_reg  <= pos.first;
            s1_emit_reg   <= pos.emit;
            s1_fe_reg     <= pos.frame_end;
            s1_addr_reg   <= blk_addr;
            s1_pix_reg    <= {s_blue_in, s_green_in, s_red_in};
            fwd_reg       <= s1_valid_reg && (s1_addr_reg == blk_addr);
            fwd_data_reg  <= sum_next;
        end
    end

    // accumulate: restart on the block's first pixel
    assign base = fwd_reg ? fwd_data_reg : rd_data;

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            if (s1_first_reg) begin
                sum_next[c] = SUM_W'(s1_pix_reg[c]);
            end else begin
                sum_next[c] = base[c*SUM_W +: SUM_W] + SUM_W'(s1_pix_reg[c]);
            end
        end
    end

    bxd_divider #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_divider (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s1_valid_reg && s1_emit_reg),
        .sums          (sum_next),
        .area          (area),
        .frame_end_in  (s1_fe_reg),
        .busy          (div_busy),
        .out_valid     (div_valid),
        .out_ready     (div_take),
        .quot          (div_quot),
        .frame_end_out (div_fe)
    );

    // output register: load when empty or being drained
    assign div_take = div_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_take) begin
            m_avg_reg <= div_quot;
            m_fe_reg  <= div_fe;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_avg   = m_avg_reg[0];
    assign m_green_avg = m_avg_reg[1];
    assign m_blue_avg  = m_avg_reg[2];
    assign m_frame_end = m_fe_reg;

endmodule

// ===== tb/box_average_downscaler_test.sv =====
// ----------------------------------------------------------------------------
// box_average_downscaler_test
// Self-checking testbench of the box average downscaler. A behavioral model
// tracks the frame position and the per-column block sums of every accepted
// pixel and queues the expected averaged pixel; a checker compares each
// output item with the oldest queued one. Directed tests cover reset values,
// register clamping, the ignored index, frame restart and the extreme sizes,
// then randomized frames run under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module box_average_downscaler_test;
    import bxd_pkg::*;

    localparam int MAX_W          = 4096;
    localparam int MAX_S          = 16;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int MAX_REPORTS    = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic frame_end;
    } avg_pixel_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    pix_t                  s_red_in    = '0;
    pix_t                  s_green_in  = '0;
    pix_t                  s_blue_in   = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    pix_t                  m_red_avg;
    pix_t                  m_green_avg;
    pix_t                  m_blue_avg;
    logic                  m_frame_end;

    // model state: registers, frame position and block column sums
    logic [LW_W-1:0] line_width_q;
    logic [FH_W-1:0] frame_height_q;
    logic [BS_W-1:0] block_scale_q;
    logic [23:0]     red_block_sum   [MAX_W];
    logic [23:0]     green_block_sum [MAX_W];
    logic [23:0]     blue_block_sum  [MAX_W];
    int              pix_col;
    int              pix_row;
    int              blk_col_ofs;
    int              blk_row_ofs;

    avg_pixel_t avg_pending[$];
    int         error_count = 0;

    // idling knobs
    int burst_max    = 8;
    int gap_max      = 4;
    int burst_left   = 0;
    int ready_run_max = 8;
    int stall_max    = 4;
    int hold_request = 0;

    box_average_downscaler u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_avg   (m_red_avg),
        .m_green_avg (m_green_avg),
        .m_blue_avg  (m_blue_avg),
        .m_frame_end (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // --------------------------------------------------------------------
    // behavioral model
    // --------------------------------------------------------------------
    task automatic restart_position();
        pix_col     = 0;
        pix_row     = 0;
        blk_col_ofs = 0;
        blk_row_ofs = 0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LINE_WIDTH: begin
                line_width_q = data[LW_W-1:0];
                restart_position();
            end
            CFG_FRAME_HEIGHT: begin
                frame_height_q = data[FH_W-1:0];
                restart_position();
            end
            CFG_BLOCK_SCALE: begin
                block_scale_q = data[BS_W-1:0];
                restart_position();
            end
            default: ;
        endcase
    endtask

    // accumulate one pixel and queue the block average on its last pixel
    task automatic predict_block_average(input pix_t r, input pix_t g, input pix_t b);
        int         w;
        int         h;
        int         s;
        int         wfull;
        int         hfull;
        int         blk;
        int         area;
        avg_pixel_t px;
        w = (line_width_q == 0) ? 1 : ((line_width_q > MAX_W) ? MAX_W : int'(line_width_q));
        h = (frame_height_q == 0) ? 1 : int'(frame_height_q);
        s = (block_scale_q == 0) ? 1 : ((block_scale_q > MAX_S) ? MAX_S : int'(block_scale_q));
        wfull = (w / s) * s;
        hfull = (h / s) * s;
        area  = s * s;
        if (pix_col < wfull && pix_row < hfull) begin
            blk = pix_col / s;
            if (blk_col_ofs == 0 && blk_row_ofs == 0) begin
                red_block_sum[blk]   = 24'(r);
                green_block_sum[blk] = 24'(g);
                blue_block_sum[blk]  = 24'(b);
            end else begin
                red_block_sum[blk]   = red_block_sum[blk] + 24'(r);
                green_block_sum[blk] = green_block_sum[blk] + 24'(g);
                blue_block_sum[blk]  = blue_block_sum[blk] + 24'(b);
            end
            if (blk_col_ofs == s - 1 && blk_row_ofs == s - 1) begin
                px.red       = pix_t'(red_block_sum[blk] / 24'(area));
                px.green     = pix_t'(green_block_sum[blk] / 24'(area));
                px.blue      = pix_t'(blue_block_sum[blk] / 24'(area));
                px.frame_end = (pix_col == wfull - 1 && pix_row == hfull - 1);
                avg_pending.push_back(px);
            end
        end
        // advance the raster position
        blk_col_ofs = (blk_col_ofs + 1 >= s) ? 0 : blk_col_ofs + 1;
        if (pix_col + 1 >= w) begin
            pix_col     = 0;
            blk_col_ofs = 0;
            blk_row_ofs = (blk_row_ofs + 1 >= s) ? 0 : blk_row_ofs + 1;
            if (pix_row + 1 >= h) begin
                pix_row     = 0;
                blk_row_ofs = 0;
            end else begin
                pix_row++;
            end
        end else begin
            pix_col++;
        end
    endtask

    // --------------------------------------------------------------------
    // stimulus helpers
    // --------------------------------------------------------------------
    task automatic set_idling(input int bmax, input int gmax, input int rmax, input int smax);
        burst_max     = bmax;
        gap_max       = gmax;
        ready_run_max = rmax;
        stall_max     = smax;
        burst_left    = 0;
    endtask

    task automatic randomize_idling();
        case ($urandom_range(0, 3))
            0: set_idling(64, 0, 64, 0);
            1: set_idling($urandom_range(1, 12), $urandom_range(1, 8),
                          $urandom_range(1, 12), $urandom_range(1, 12));
            2: set_idling(64, 0, $urandom_range(1, 4), $urandom_range(1, 12));
            default: set_idling($urandom_range(1, 4), $urandom_range(1, 8), 64, 0);
        endcase
    endtask

    // send one item; valid stays high afterwards until a gap or a drain
    task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_block_average(r, g, b);
    endtask

    function automatic pix_t pick_component(input bit extremes);
        if (extremes) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return '1;
                default: return pix_t'($urandom);
            endcase
        end
        return pix_t'($urandom);
    endfunction

    task automatic send_random_pixels(input int n, input bit extremes);
        for (int i = 0; i < n; i++) begin
            send_pixel(pick_component(extremes), pick_component(extremes),
                       pick_component(extremes));
        end
    endtask

    // hold the write enable; the caller ends the write burst with cfg_end
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        apply_register(idx, data);
    endtask

    task automatic cfg_end();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // unused upper data bits get random values; the block must drop them
    task automatic set_frame(input int w, input int h, input int s);
        write_reg(CFG_LINE_WIDTH,
                  CFG_DATA_W'(w[LW_W-1:0]) | (CFG_DATA_W'($urandom) << LW_W));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_BLOCK_SCALE,
                  CFG_DATA_W'(s[BS_W-1:0]) | (CFG_DATA_W'($urandom) << BS_W));
        cfg_end();
    endtask

    // stop sending, wait for every expected item, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (avg_pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // --------------------------------------------------------------------
    // receiver: own ready pattern, plus a long hold-off on request
    // --------------------------------------------------------------------
    initial begin : ready_pattern
        int run;
        int hold_len;
        forever begin
            if (hold_request > 0) begin
                hold_len     = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end
            run = $urandom_range(1, ready_run_max);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            run = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
            if (run > 0) begin
                m_ready <= 1'b0;
                repeat (run) @(posedge aclk);
            end
        end
    end

    // --------------------------------------------------------------------
    // checker
    // --------------------------------------------------------------------
    task automatic check_field(input string name, input logic [PIX_W-1:0] exp_v,
                               input logic [PIX_W-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        avg_pixel_t px;
        if (aresetn && m_valid && m_ready) begin
            if (avg_pending.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected item, expected none, actual %h %h %h %b",
                             $time, m_red_avg, m_green_avg, m_blue_avg, m_frame_end);
            end else begin
                px = avg_pending.pop_front();
                check_field("red_avg", px.red, m_red_avg);
                check_field("green_avg", px.green, m_green_avg);
                check_field("blue_avg", px.blue, m_blue_avg);
                check_field("frame_end", PIX_W'(px.frame_end), PIX_W'(m_frame_end));
            end
        end
    end

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------
    // reset values: 640 x 480 at scale 1 passes pixels through
    task automatic test_reset_values();
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel(16'hAAAA, 16'h5555, 16'h1234);
        drain();
    endtask

    // zero width, height and scale all act as 1: every pixel ends a frame
    task automatic test_zero_registers();
        set_frame(0, 0, 0);
        send_pixel(16'h5555, 16'hAAAA, 16'hFEDC);
        send_pixel(16'h0001, 16'h8000, 16'h7FFF);
        drain();
    endtask

    // oversize scale clamps to 16, so a 5 x 5 image holds no whole block
    task automatic test_oversize_scale();
        set_frame(5, 5, 31);
        send_random_pixels(3, 1'b1);
        drain();
    endtask

    // a write to the unused index must not restart the frame
    task automatic test_unknown_index();
        set_frame(4, 2, 2);
        send_random_pixels(2, 1'b0);
        drain();
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        cfg_end();
        send_random_pixels(6, 1'b0);
        drain();
    endtask

    // a register write mid-frame restarts the position
    task automatic test_restart_on_write();
        set_frame(4, 4, 2);
        send_random_pixels(3, 1'b0);
        drain();
        write_reg(CFG_BLOCK_SCALE, CFG_DATA_W'(2));
        cfg_end();
        send_random_pixels(8, 1'b0);
        drain();
    endtask

    // tallest frame register value
    task automatic test_tall_frame();
        set_frame(2, 65535, 2);
        send_random_pixels(4, 1'b1);
        drain();
    endtask

    // largest block filled with full-scale pixels: largest sums
    task automatic test_full_block();
        set_frame(16, 16, 16);
        for (int i = 0; i < 256; i++) send_pixel('1, '1, '1);
        drain();
    endtask

    // line width written as all ones clamps to 4096; run past the row wrap
    task automatic test_wide_line();
        set_idling(64, 0, 64, 0);
        write_reg(CFG_LINE_WIDTH, 16'hFFFF);
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
        write_reg(CFG_BLOCK_SCALE, CFG_DATA_W'(1));
        cfg_end();
        send_random_pixels(MAX_W + 8, 1'b0);
        drain();
    endtask

    // long receiver hold-off while items keep coming: the input must stall
    task automatic test_backpressure();
        set_idling(64, 0, 64, 0);
        set_frame(8, 4, 1);
        hold_request = 300;
        send_random_pixels(48, 1'b0);
        drain();
        set_frame(6, 4, 2);
        hold_request = 300;
        send_random_pixels(48, 1'b0);
        drain();
    endtask

    // random frame geometry, content and idling
    task automatic test_random_frames();
        int sent;
        int s;
        int w;
        int h;
        int n;
        bit extremes;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: s = $urandom_range(1, 2);
                4, 5, 6, 7: s = $urandom_range(3, 6);
                default:    s = $urandom_range(7, MAX_S);
            endcase
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, s) : $urandom_range(s, 4 * s + 3);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, s) : $urandom_range(s, 4 * s + 3);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            if (n > 600) n = 600;
            extremes = ($urandom_range(0, 4) == 0);
            randomize_idling();
            set_frame(w, h, s);
            send_random_pixels(n, extremes);
            drain();
            sent += n;
        end
    endtask

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial begin : main_seq
        line_width_q   = LINE_WIDTH_RST;
        frame_height_q = FRAME_HEIGHT_RST;
        block_scale_q  = BLOCK_SCALE_RST;
        for (int i = 0; i < MAX_W; i++) begin
            red_block_sum[i]   = '0;
            green_block_sum[i] = '0;
            blue_block_sum[i]  = '0;
        end
        restart_position();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_zero_registers();
        test_oversize_scale();
        test_unknown_index();
        test_restart_on_write();
        test_tall_frame();
        test_full_block();
        test_wide_line();
        test_backpressure();
        test_random_frames();

        drain();
        repeat (40) @(posedge aclk);
        if (avg_pending.size() != 0) begin
            error_count++;
            $display("%0t: missing items, expected %0d more, actual 0",
                     $time, avg_pending.size());
        end
        if (error_count == 0) begin
            $display("box_average_downscaler_test passed");
        end else begin
            $display("box_average_downscaler_test failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #12000000;
        $display("box_average_downscaler_test failed");
        $finish;
    end

endmodule

// ===== box_average_downscaler.f =====
sv/bxd_pkg.sv
sv/bxd_ram.sv
sv/bxd_position.sv
sv/bxd_divider.sv
sv/box_average_downscaler.sv
tb/box_average_downscaler_test.sv
